// ----- hdl/mwau_pkg.sv -----
package mwau_pkg;

   localparam int VALUE_BITS        = 64;
   localparam int WORD_BITS_DEFAULT = 64;

   // Operation selectors.
   localparam logic [3:0] OP_ADD    = 4'd0;
   localparam logic [3:0] OP_SUB    = 4'd1;
   localparam logic [3:0] OP_NEG    = 4'd2;
   localparam logic [3:0] OP_MUL    = 4'd3;
   localparam logic [3:0] OP_ADDMUL = 4'd4;
   localparam logic [3:0] OP_SUBMUL = 4'd5;
   localparam logic [3:0] OP_INV    = 4'd6;
   localparam logic [3:0] OP_DIV    = 4'd7;
   localparam logic [3:0] OP_ADD_SI = 4'd8;
   localparam logic [3:0] OP_MUL_SI = 4'd9;
   localparam logic [3:0] OP_DIV_SI = 4'd10;
   localparam logic [3:0] OP_SET_SI = 4'd11;
   localparam logic [3:0] OP_SET_UI = 4'd12;
   localparam logic [3:0] OP_DOT    = 4'd13;

   // Operand register selects (also bit positions of the reduction mask).
   localparam logic [2:0] SEL_A = 3'd0;
   localparam logic [2:0] SEL_B = 3'd1;
   localparam logic [2:0] SEL_C = 3'd2;
   localparam logic [2:0] SEL_D = 3'd3;
   localparam logic [2:0] SEL_V = 3'd4;
   localparam int         NUM_SEL = 5;

   // First addend of the modular adder.
   localparam logic [2:0] P_ZERO = 3'd0;
   localparam logic [2:0] P_A    = 3'd1;
   localparam logic [2:0] P_C    = 3'd2;
   localparam logic [2:0] P_D    = 3'd3;
   localparam logic [2:0] P_F0   = 3'd4;

   // Second addend of the modular adder.
   localparam logic [2:0] Q_A = 3'd0;
   localparam logic [2:0] Q_B = 3'd1;
   localparam logic [2:0] Q_V = 3'd2;
   localparam logic [2:0] Q_M = 3'd3;
   localparam logic [2:0] Q_T = 3'd4;

   // Second factor of the multiplier.
   localparam logic [1:0] MY_B  = 2'd0;
   localparam logic [1:0] MY_V  = 2'd1;
   localparam logic [1:0] MY_T  = 2'd2;
   localparam logic [1:0] MY_F1 = 2'd3;

   // Destination of the modular adder.
   localparam logic [1:0] DST_FIN = 2'd0;
   localparam logic [1:0] DST_T   = 2'd1;
   localparam logic [1:0] DST_F1  = 2'd2;
   localparam logic [1:0] DST_V   = 2'd3;

   typedef struct packed {
      logic [3:0]                    req_type;
      logic [VALUE_BITS-1:0]         operand_a;
      logic [VALUE_BITS-1:0]         operand_b;
      logic [VALUE_BITS-1:0]         operand_c;
      logic signed [VALUE_BITS-1:0]  signed_value;
      logic                          use_initial;
      logic                          subtract;
      logic                          last_term;
   } request_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] result;
      logic                  status;
   } response_type;

   typedef struct packed {
      logic       load;
      logic [2:0] sel;
      logic       div_start;
      logic       div_euclid;
      logic       red_write;
      logic       mul_start;
      logic       mul_x_q;
      logic [1:0] mul_y_sel;
      logic       comb_en;
      logic [2:0] p_sel;
      logic [2:0] q_sel;
      logic       q_neg;
      logic [1:0] dest;
      logic       inv_init;
      logic       eu_update;
      logic       inv_finish;
      logic       dot_write;
      logic       dot_clear;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic src_small;
      logic e1_zero;
      logic v_neg;
      logic div_done;
      logic mul_done;
   } dp_status_type;

endpackage

// ----- hdl/mwau_div.sv -----
module mwau_div import mwau_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [WORD_BITS-1:0]  divisor,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [WORD_BITS-1:0]  remainder,
   output logic                  done
);

   localparam int CNT_BITS = $clog2(VALUE_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [WORD_BITS-1:0]  rem_ff, rem_in;
   logic [WORD_BITS-1:0]  dvs_ff, dvs_in;
   logic [WORD_BITS:0]    shifted;
   logic [WORD_BITS:0]    diff;
   logic                  ge;

   // One restoring step per cycle, dividend bits taken MSB first.
   assign shifted = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], ge};
         rem_in = ge ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ----- hdl/mwau_mulmod.sv -----
module mwau_mulmod import mwau_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] x,
   input  logic [WORD_BITS-1:0] y,
   input  logic [WORD_BITS-1:0] n,
   output logic [WORD_BITS-1:0] product,
   output logic                 done
);

   localparam int CNT_BITS = $clog2(WORD_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 phase_ff, phase_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] x_ff, x_in;
   logic [WORD_BITS-1:0] y_ff, y_in;
   logic [WORD_BITS-1:0] n_ff, n_in;
   logic [WORD_BITS-1:0] r_ff, r_in;
   logic [WORD_BITS-1:0] addend;
   logic [WORD_BITS:0]   sum;
   logic [WORD_BITS:0]   sum_sub;
   logic [WORD_BITS-1:0] sum_mod;

   // Double-and-add, MSB first: the doubling and the conditional add take turns
   // through the same modular adder.
   assign addend  = phase_ff ? x_ff : r_ff;
   assign sum     = {1'b0, r_ff} + {1'b0, addend};
   assign sum_sub = sum - {1'b0, n_ff};
   assign sum_mod = (sum >= {1'b0, n_ff}) ? sum_sub[WORD_BITS-1:0] : sum[WORD_BITS-1:0];

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      n_in     = n_ff;
      r_in     = r_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         cnt_in   = '0;
         x_in     = x;
         y_in     = y;
         n_in     = n;
         r_in     = '0;
      end else if (busy_ff) begin
         phase_in = ~phase_ff;
         if (!phase_ff) begin
            r_in = sum_mod;
         end else begin
            if (y_ff[WORD_BITS-1]) begin
               r_in = sum_mod;
            end
            y_in   = {y_ff[WORD_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(WORD_BITS - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      n_ff <= n_in;
      r_ff <= r_in;
   end

   assign product = r_ff;
   assign done    = done_ff;

endmodule

// ----- hdl/mwau_datapath.sv -----
module mwau_datapath import mwau_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  request_type           req_data,
   input  logic                  csr_write,
   input  logic [VALUE_BITS-1:0] csr_data,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output response_type          rsp_data
);

   logic [WORD_BITS-1:0]  mod_ff;
   logic [WORD_BITS-1:0]  n_ff;
   logic [WORD_BITS-1:0]  a_ff, b_ff, c_ff, d_ff, t_ff;
   logic [WORD_BITS-1:0]  e0_ff, e1_ff, f0_ff, f1_ff, fin_ff;
   logic [VALUE_BITS-1:0] v_ff;
   logic                  vneg_ff;
   logic                  err_ff;
   response_type          rsp_ff;

   logic [VALUE_BITS-1:0] sel_val;
   logic [WORD_BITS-1:0]  sel_word;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [WORD_BITS-1:0]  div_divisor;
   logic [VALUE_BITS-1:0] div_quo;
   logic [WORD_BITS-1:0]  div_rem;
   logic                  div_done;
   logic [WORD_BITS-1:0]  quo_word;
   logic [WORD_BITS-1:0]  q_reduced;
   logic [WORD_BITS-1:0]  mul_x, mul_y, mul_p;
   logic                  mul_done;
   logic [WORD_BITS-1:0]  p_val, q_val, q_eff;
   logic [WORD_BITS:0]    sum, sum_sub;
   logic [WORD_BITS-1:0]  comb_out;
   logic                  load_neg;
   logic [VALUE_BITS-1:0] load_v;

   always_comb begin
      case (cmd.sel)
         SEL_A:   sel_val = VALUE_BITS'(a_ff);
         SEL_B:   sel_val = VALUE_BITS'(b_ff);
         SEL_C:   sel_val = VALUE_BITS'(c_ff);
         SEL_D:   sel_val = VALUE_BITS'(d_ff);
         SEL_V:   sel_val = v_ff;
         default: sel_val = '0;
      endcase
   end
   assign sel_word = sel_val[WORD_BITS-1:0];

   assign div_dividend = cmd.div_euclid ? VALUE_BITS'(e0_ff) : sel_val;
   assign div_divisor  = cmd.div_euclid ? e1_ff : n_ff;

   mwau_div #(.WORD_BITS(WORD_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   // A Euclid quotient never exceeds n, so q mod n only folds q == n to zero.
   assign quo_word  = div_quo[WORD_BITS-1:0];
   assign q_reduced = (quo_word == n_ff) ? '0 : quo_word;

   assign mul_x = cmd.mul_x_q ? q_reduced : a_ff;
   always_comb begin
      case (cmd.mul_y_sel)
         MY_B:    mul_y = b_ff;
         MY_V:    mul_y = v_ff[WORD_BITS-1:0];
         MY_T:    mul_y = t_ff;
         MY_F1:   mul_y = f1_ff;
         default: mul_y = b_ff;
      endcase
   end

   mwau_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .n       (n_ff),
      .product (mul_p),
      .done    (mul_done)
   );

   // Shared modular adder: p + q or p - q, both operands already below n.
   always_comb begin
      case (cmd.p_sel)
         P_ZERO:  p_val = '0;
         P_A:     p_val = a_ff;
         P_C:     p_val = c_ff;
         P_D:     p_val = d_ff;
         P_F0:    p_val = f0_ff;
         default: p_val = '0;
      endcase
      case (cmd.q_sel)
         Q_A:     q_val = a_ff;
         Q_B:     q_val = b_ff;
         Q_V:     q_val = v_ff[WORD_BITS-1:0];
         Q_M:     q_val = mul_p;
         Q_T:     q_val = t_ff;
         default: q_val = '0;
      endcase
   end

   assign q_eff    = (cmd.q_neg && q_val != '0) ? n_ff - q_val : q_val;
   assign sum      = {1'b0, p_val} + {1'b0, q_eff};
   assign sum_sub  = sum - {1'b0, n_ff};
   assign comb_out = (sum >= {1'b0, n_ff}) ? sum_sub[WORD_BITS-1:0] : sum[WORD_BITS-1:0];

   assign load_neg = req_data.signed_value[VALUE_BITS-1] && (req_data.req_type != OP_SET_UI);
   assign load_v   = load_neg ? VALUE_BITS'(0) - VALUE_BITS'(req_data.signed_value)
                              : VALUE_BITS'(req_data.signed_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= WORD_BITS'(1);
      end else if (csr_write) begin
         mod_ff <= csr_data[WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= '0;
      end else if (cmd.dot_clear) begin
         d_ff <= '0;
      end else if (cmd.dot_write) begin
         d_ff <= t_ff;
      end else if (cmd.red_write && cmd.sel == SEL_D) begin
         d_ff <= div_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff    <= (mod_ff == '0) ? WORD_BITS'(1) : mod_ff;
         a_ff    <= req_data.operand_a[WORD_BITS-1:0];
         b_ff    <= req_data.operand_b[WORD_BITS-1:0];
         c_ff    <= req_data.operand_c[WORD_BITS-1:0];
         v_ff    <= load_v;
         vneg_ff <= load_neg;
         err_ff  <= 1'b0;
      end
      if (cmd.red_write) begin
         case (cmd.sel)
            SEL_A:   a_ff <= div_rem;
            SEL_B:   b_ff <= div_rem;
            SEL_C:   c_ff <= div_rem;
            SEL_V:   v_ff <= VALUE_BITS'(div_rem);
            default: ;
         endcase
      end
      if (cmd.inv_init) begin
         e0_ff <= n_ff;
         e1_ff <= sel_word;
         f0_ff <= '0;
         f1_ff <= (n_ff == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
      end
      if (cmd.eu_update) begin
         e0_ff <= e1_ff;
         e1_ff <= div_rem;
         f0_ff <= f1_ff;
      end
      if (cmd.inv_finish) begin
         t_ff   <= (e0_ff == WORD_BITS'(1)) ? f0_ff : '0;
         err_ff <= (e0_ff != WORD_BITS'(1));
      end
      if (cmd.comb_en) begin
         case (cmd.dest)
            DST_FIN: fin_ff <= comb_out;
            DST_T:   t_ff   <= comb_out;
            DST_F1:  f1_ff  <= comb_out;
            DST_V:   v_ff   <= VALUE_BITS'(comb_out);
            default: ;
         endcase
      end
      if (cmd.out_load) begin
         rsp_ff.result <= VALUE_BITS'(fin_ff);
         rsp_ff.status <= err_ff;
      end
   end

   assign status.src_small = sel_val < VALUE_BITS'(n_ff);
   assign status.e1_zero   = (e1_ff == '0);
   assign status.v_neg     = vneg_ff;
   assign status.div_done  = div_done;
   assign status.mul_done  = mul_done;
   assign rsp_data         = rsp_ff;

endmodule

// ----- hdl/mwau_ctrl.sv -----
module mwau_ctrl import mwau_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  request_type   req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_RED      = 4'd1;
   localparam logic [3:0] S_RED_WAIT = 4'd2;
   localparam logic [3:0] S_VFIX     = 4'd3;
   localparam logic [3:0] S_INV_INIT = 4'd4;
   localparam logic [3:0] S_EU_CHK   = 4'd5;
   localparam logic [3:0] S_EU_DIV   = 4'd6;
   localparam logic [3:0] S_EU_MUL   = 4'd7;
   localparam logic [3:0] S_EU_UPD   = 4'd8;
   localparam logic [3:0] S_EU_FIN   = 4'd9;
   localparam logic [3:0] S_MUL      = 4'd10;
   localparam logic [3:0] S_MUL_WAIT = 4'd11;
   localparam logic [3:0] S_COMB     = 4'd12;
   localparam logic [3:0] S_DOT      = 4'd13;
   localparam logic [3:0] S_OUT      = 4'd14;

   logic [3:0]         state_ff, state_in;
   logic [3:0]         op_ff, op_in;
   logic               last_ff, last_in;
   logic               init_ff, init_in;
   logic               sub_ff, sub_in;
   logic [NUM_SEL-1:0] need_ff, need_in;
   logic [2:0]         ridx_ff, ridx_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Operands that must be brought below n for each operation.
   function automatic logic [NUM_SEL-1:0] need_mask(input logic [3:0] op);
      logic [NUM_SEL-1:0] m;
      m = '0;
      case (op)
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            m[SEL_A] = 1'b1;
            m[SEL_B] = 1'b1;
         end
         OP_NEG, OP_INV: m[SEL_A] = 1'b1;
         OP_ADDMUL, OP_SUBMUL: begin
            m[SEL_A] = 1'b1;
            m[SEL_B] = 1'b1;
            m[SEL_C] = 1'b1;
         end
         OP_ADD_SI, OP_MUL_SI, OP_DIV_SI: begin
            m[SEL_A] = 1'b1;
            m[SEL_V] = 1'b1;
         end
         OP_SET_SI, OP_SET_UI: m[SEL_V] = 1'b1;
         OP_DOT: m = '1;
         default: m = '0;
      endcase
      return m;
   endfunction

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      last_in  = last_ff;
      init_in  = init_ff;
      sub_in   = sub_ff;
      need_in  = need_ff;
      ridx_in  = ridx_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = req_data.req_type;
               last_in  = req_data.last_term;
               init_in  = req_data.use_initial;
               sub_in   = req_data.subtract;
               need_in  = need_mask(req_data.req_type);
               ridx_in  = '0;
               if (req_data.req_type <= OP_DOT) begin
                  state_in = S_RED;
               end
            end
         end
         S_RED: begin
            cmd.sel = ridx_ff;
            if (ridx_ff == 3'(NUM_SEL)) begin
               state_in = S_VFIX;
            end else if (!need_ff[ridx_ff] || status.src_small) begin
               ridx_in = ridx_ff + 3'd1;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_RED_WAIT;
            end
         end
         S_RED_WAIT: begin
            cmd.sel = ridx_ff;
            if (status.div_done) begin
               cmd.red_write = 1'b1;
               ridx_in       = ridx_ff + 3'd1;
               state_in      = S_RED;
            end
         end
         S_VFIX: begin
            cmd.comb_en = 1'b1;
            cmd.p_sel   = P_ZERO;
            cmd.q_sel   = Q_V;
            cmd.q_neg   = status.v_neg;
            cmd.dest    = DST_V;
            if (op_ff == OP_INV || op_ff == OP_DIV || op_ff == OP_DIV_SI) begin
               state_in = S_INV_INIT;
            end else if (op_ff == OP_MUL || op_ff == OP_ADDMUL || op_ff == OP_SUBMUL
                         || op_ff == OP_MUL_SI || op_ff == OP_DOT) begin
               state_in = S_MUL;
            end else begin
               state_in = S_COMB;
            end
         end
         S_INV_INIT: begin
            cmd.inv_init = 1'b1;
            cmd.sel = (op_ff == OP_INV) ? SEL_A : (op_ff == OP_DIV) ? SEL_B : SEL_V;
            state_in = S_EU_CHK;
         end
         S_EU_CHK: begin
            cmd.div_euclid = 1'b1;
            if (status.e1_zero) begin
               state_in = S_EU_FIN;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_EU_DIV;
            end
         end
         S_EU_DIV: begin
            if (status.div_done) begin
               cmd.mul_start = 1'b1;
               cmd.mul_x_q   = 1'b1;
               cmd.mul_y_sel = MY_F1;
               state_in      = S_EU_MUL;
            end
         end
         S_EU_MUL: begin
            if (status.mul_done) begin
               state_in = S_EU_UPD;
            end
         end
         S_EU_UPD: begin
            cmd.eu_update = 1'b1;
            cmd.comb_en   = 1'b1;
            cmd.p_sel     = P_F0;
            cmd.q_sel     = Q_M;
            cmd.q_neg     = 1'b1;
            cmd.dest      = DST_F1;
            state_in      = S_EU_CHK;
         end
         S_EU_FIN: begin
            cmd.inv_finish = 1'b1;
            state_in = (op_ff == OP_INV) ? S_COMB : S_MUL;
         end
         S_MUL: begin
            cmd.mul_start = 1'b1;
            if (op_ff == OP_MUL_SI) begin
               cmd.mul_y_sel = MY_V;
            end else if (op_ff == OP_DIV || op_ff == OP_DIV_SI) begin
               cmd.mul_y_sel = MY_T;
            end else begin
               cmd.mul_y_sel = MY_B;
            end
            state_in = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (status.mul_done) begin
               state_in = S_COMB;
            end
         end
         S_COMB: begin
            cmd.comb_en = 1'b1;
            cmd.dest    = DST_FIN;
            state_in    = S_OUT;
            case (op_ff)
               OP_ADD: begin
                  cmd.p_sel = P_A;
                  cmd.q_sel = Q_B;
               end
               OP_SUB: begin
                  cmd.p_sel = P_A;
                  cmd.q_sel = Q_B;
                  cmd.q_neg = 1'b1;
               end
               OP_NEG: begin
                  cmd.p_sel = P_ZERO;
                  cmd.q_sel = Q_A;
                  cmd.q_neg = 1'b1;
               end
               OP_ADDMUL: begin
                  cmd.p_sel = P_C;
                  cmd.q_sel = Q_M;
               end
               OP_SUBMUL: begin
                  cmd.p_sel = P_C;
                  cmd.q_sel = Q_M;
                  cmd.q_neg = 1'b1;
               end
               OP_INV: begin
                  cmd.p_sel = P_ZERO;
                  cmd.q_sel = Q_T;
               end
               OP_ADD_SI: begin
                  cmd.p_sel = P_A;
                  cmd.q_sel = Q_V;
               end
               OP_SET_SI, OP_SET_UI: begin
                  cmd.p_sel = P_ZERO;
                  cmd.q_sel = Q_V;
               end
               OP_DOT: begin
                  cmd.p_sel = P_D;
                  cmd.q_sel = Q_M;
                  cmd.dest  = DST_T;
                  state_in  = S_DOT;
               end
               default: begin
                  cmd.p_sel = P_ZERO;
                  cmd.q_sel = Q_M;
               end
            endcase
         end
         S_DOT: begin
            if (last_ff) begin
               cmd.dot_clear = 1'b1;
               cmd.comb_en   = 1'b1;
               cmd.p_sel     = init_ff ? P_C : P_ZERO;
               cmd.q_sel     = Q_T;
               cmd.q_neg     = sub_ff;
               cmd.dest      = DST_FIN;
               state_in      = S_OUT;
            end else begin
               cmd.dot_write = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ridx_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ridx_ff      <= ridx_in;
      end
      op_ff   <= op_in;
      last_ff <= last_in;
      init_ff <= init_in;
      sub_ff  <= sub_in;
      need_ff <= need_in;
   end

   assign rsp_valid = rsp_valid_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.req_type <= OP_DOT) |=> state_ff != S_IDLE)
      else $error("accepted operation did not start");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_RED_WAIT || state_ff == S_EU_DIV))
      else $error("divider finished outside a wait state");

   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> (state_ff == S_MUL_WAIT || state_ff == S_EU_MUL))
      else $error("multiplier finished outside a wait state");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) |=>
      (state_ff == S_IDLE && rsp_valid_ff))
      else $error("result not presented when output slot was free");

endmodule

// ----- hdl/modular_word_arithmetic_unit.sv -----
// Modular word arithmetic unit: computes add, sub, neg, mul, c+a*b, c-a*b, inverse,
// division, the signed-operand forms, set_si/set_ui and dot products modulo the
// modulus n held in the one CSR (its low WORD_BITS bits; zero acts as one).
// One item is worked at a time. Every operand that the operation uses and that
// arrives not below n is first reduced by a 64-step serial divider, and a modular
// product is formed by a double-and-add multiplier doing one modular add per
// cycle. Inverse and division run extended Euclid, with setup and wrap-up around
// its steps. A finished result waits in the output register while the next beat
// is already taken. Non-last dot terms produce no result.
module modular_word_arithmetic_unit import mwau_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  request_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output response_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [VALUE_BITS-1:0] csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // The modulus register takes a write in any cycle.
   assign csr_ready = 1'b1;

   mwau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mwau_datapath #(.WORD_BITS(WORD_BITS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
